// ===== design/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

	localparam int ARENA_WORDS = 1024;
	localparam int ADDR_W      = $clog2(ARENA_WORDS);
	localparam int FIELD_W     = 11;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [FIELD_W-1:0] LINK_END    = '1;
	localparam logic [FIELD_W-1:0] ARENA_MIN   = FIELD_W'(2);
	localparam logic [FIELD_W-1:0] ARENA_MAX   = FIELD_W'(ARENA_WORDS);
	localparam logic [FIELD_W-1:0] ARENA_RESET =
		FIELD_W'((ARENA_WORDS < 1024) ? ARENA_WORDS : 1024);

	localparam logic [PADDR_W-3:0] REG_ARENA_UNITS = '0;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic [FIELD_W-1:0] alloc_size;
		logic [ADDR_W-1:0]  free_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] grant_addr;
	} rsp_t;

	typedef struct packed {
		logic [FIELD_W-1:0] next;
		logic [FIELD_W-1:0] size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic [FIELD_W-1:0] arena_units;
		logic               fmt_req;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		hdr_t              wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== design/first_fit_free_list_allocator.sv =====
// Alloc: IDLE, then CHECK for each header visited, CUT on a split, LINK, RESP; free: IDLE, FREE,
// RESP; a reject or no fit goes on to RESP. The walk reads one header per cycle from the RAM.
// Requests: one at a time; the next is accepted in the cycle after the result is registered.
// Reset: arena_units = 1024, one free block at unit 0; a 1-cycle format write of header 0
// follows reset and every arena_units write, with the request side held off.
`default_nettype none

module first_fit_free_list_allocator import ffa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire req_t               in_data,
	// result channel
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      rsp_t               out_data,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready
);

	cfg_t             cfg;
	mem_req_t         mem;
	logic [HDR_W-1:0] mem_rdata;

	// arena_units register; a write also kicks off the format
	ffa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: first-fit walk, split, unlink, push on free, result register
	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem       (mem),
		.mem_rdata (hdr_t'(mem_rdata))
	);

	// header store: {next, size} per unit, contents undefined until written
	ffa_ram #(
		.WIDTH (HDR_W),
		.DEPTH (ARENA_WORDS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== design/ffa_ram.sv =====
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/ffa_cfg.sv =====
`default_nettype none

module ffa_cfg import ffa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	output      cfg_t               cfg
);

	logic               hit;
	logic               wr;
	logic [FIELD_W-1:0] wval;
	logic [FIELD_W-1:0] arena_q;

	assign hit    = paddr[PADDR_W-1:2] == REG_ARENA_UNITS;
	assign wr     = psel && penable && pwrite && hit;
	assign pready = 1'b1;
	assign prdata = hit ? PDATA_W'(arena_q) : '0;

	// clamp to the legal arena range
	always_comb begin
		wval = pwdata[FIELD_W-1:0];
		if (wval < ARENA_MIN) begin
			wval = ARENA_MIN;
		end else if (wval > ARENA_MAX) begin
			wval = ARENA_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= ARENA_RESET;
		end else if (wr) begin
			arena_q <= wval;
		end
	end

	assign cfg.arena_units = arena_q;
	assign cfg.fmt_req     = wr;

endmodule

`default_nettype wire

// ===== design/ffa_ctrl.sv =====
`default_nettype none

module ffa_ctrl import ffa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic in_valid,
	output      logic in_ready,
	input  wire req_t in_data,
	output      logic out_valid,
	input  wire logic out_ready,
	output      rsp_t out_data,
	output      mem_req_t mem,
	input  wire hdr_t mem_rdata
);

	typedef enum logic [6:0] {
		S_FMT   = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_CUT   = 7'b0001000,
		S_LINK  = 7'b0010000,
		S_FREE  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [FIELD_W-1:0] list_head_q;
	logic [FIELD_W-1:0] want_q;
	logic [FIELD_W-1:0] cur_q;
	logic [FIELD_W-1:0] prev_q;
	logic [FIELD_W-1:0] prev_size_q;
	logic [FIELD_W-1:0] steps_q;
	logic [FIELD_W-1:0] nxt_q;
	logic [FIELD_W-1:0] split_q;
	logic [FIELD_W-1:0] split_size_q;
	logic               split_hit_q;
	rsp_t               res_q;
	logic               out_valid_q;
	rsp_t               out_data_q;

	logic               accept;
	logic [FIELD_W-1:0] arena;
	logic               free_ok;
	logic [ADDR_W-1:0]  free_hdr;
	logic               fits;
	logic [FIELD_W:0]   split_w;
	logic               do_split;
	logic [FIELD_W-1:0] size_new;
	logic [FIELD_W-1:0] steps_nx;
	logic               nxt_ok;
	logic [FIELD_W-1:0] succ;
	logic [FIELD_W-1:0] prev_size_eff;

	assign arena    = cfg.arena_units;
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	assign free_ok  = (in_data.free_addr != '0) &&
		({1'b0, in_data.free_addr} < arena);
	assign free_hdr = in_data.free_addr - ADDR_W'(1);

	// first-fit test on the header just read
	assign fits     = mem_rdata.size >= want_q;
	assign split_w  = {1'b0, cur_q} + (FIELD_W+1)'(1) + {1'b0, want_q};
	assign do_split = ({1'b0, mem_rdata.size} > ({1'b0, want_q} + (FIELD_W+1)'(1))) &&
		(split_w < {1'b0, arena});
	assign size_new = mem_rdata.size - want_q - FIELD_W'(1);
	assign steps_nx = steps_q + FIELD_W'(1);
	assign nxt_ok   = (mem_rdata.next < arena) && (steps_nx < arena);

	assign succ          = split_hit_q ? split_q : nxt_q;
	// a predecessor that is the new split header carries the fresh size
	assign prev_size_eff = (split_hit_q && prev_q == split_q) ? split_size_q : prev_size_q;

	always_comb begin
		mem = '0;
		unique case (state_q)
			S_FMT: begin
				mem.we         = 1'b1;
				mem.waddr      = '0;
				mem.wdata.next = LINK_END;
				mem.wdata.size = arena - FIELD_W'(1);
			end
			S_IDLE: begin
				if (accept) begin
					if (in_data.req_type == REQ_FREE) begin
						mem.re    = free_ok;
						mem.raddr = free_hdr;
					end else begin
						mem.re    = (in_data.alloc_size != '0) && (list_head_q < arena);
						mem.raddr = list_head_q[ADDR_W-1:0];
					end
				end
			end
			S_CHECK: begin
				if (fits) begin
					mem.we         = do_split;
					mem.waddr      = split_w[ADDR_W-1:0];
					mem.wdata.next = mem_rdata.next;
					mem.wdata.size = size_new;
				end else begin
					mem.re    = nxt_ok;
					mem.raddr = mem_rdata.next[ADDR_W-1:0];
				end
			end
			S_CUT: begin
				mem.we         = 1'b1;
				mem.waddr      = cur_q[ADDR_W-1:0];
				mem.wdata.next = nxt_q;
				mem.wdata.size = want_q;
			end
			S_LINK: begin
				mem.we         = prev_q != LINK_END;
				mem.waddr      = prev_q[ADDR_W-1:0];
				mem.wdata.next = succ;
				mem.wdata.size = prev_size_eff;
			end
			S_FREE: begin
				mem.we         = 1'b1;
				mem.waddr      = cur_q[ADDR_W-1:0];
				mem.wdata.next = list_head_q;
				mem.wdata.size = mem_rdata.size;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FMT;
			list_head_q <= '0;
		end else if (cfg.fmt_req) begin
			state_q <= S_FMT;
		end else begin
			unique case (state_q)
				S_FMT: begin
					list_head_q <= '0;
					state_q     <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						want_q      <= in_data.alloc_size;
						prev_q      <= LINK_END;
						steps_q     <= '0;
						split_hit_q <= 1'b0;
						if (in_data.req_type == REQ_FREE) begin
							cur_q <= {1'b0, free_hdr};
							res_q <= '{status: ST_REJECT, grant_addr: '0};
							if (free_ok) begin
								state_q <= S_FREE;
							end else begin
								state_q <= S_RESP;
							end
						end else begin
							cur_q <= list_head_q;
							if (in_data.alloc_size == '0) begin
								res_q   <= '{status: ST_REJECT, grant_addr: '0};
								state_q <= S_RESP;
							end else if (list_head_q < arena) begin
								res_q   <= '{status: ST_NOFIT, grant_addr: '0};
								state_q <= S_CHECK;
							end else begin
								res_q   <= '{status: ST_NOFIT, grant_addr: '0};
								state_q <= S_RESP;
							end
						end
					end
				end
				S_CHECK: begin
					if (fits) begin
						nxt_q        <= mem_rdata.next;
						split_q      <= split_w[FIELD_W-1:0];
						split_size_q <= size_new;
						split_hit_q  <= do_split;
						state_q      <= do_split ? S_CUT : S_LINK;
					end else begin
						prev_q      <= cur_q;
						prev_size_q <= mem_rdata.size;
						cur_q       <= mem_rdata.next;
						steps_q     <= steps_nx;
						if (!nxt_ok) begin
							res_q   <= '{status: ST_NOFIT, grant_addr: '0};
							state_q <= S_RESP;
						end
					end
				end
				S_CUT: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					if (prev_q == LINK_END) begin
						list_head_q <= succ;
					end
					res_q   <= '{status: ST_DONE,
						grant_addr: cur_q[ADDR_W-1:0] + ADDR_W'(1)};
					state_q <= S_RESP;
				end
				S_FREE: begin
					list_head_q <= cur_q;
					res_q       <= '{status: ST_DONE, grant_addr: '0};
					state_q     <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_FMT;
				end
			endcase
		end
	end

	// output register: holds the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem.we && mem.re))
		else $error("header read and write issued together");

	a_beat_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result beat raised outside response state");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> steps_q < arena)
		else $error("free list walk exceeded arena bound");

	a_fmt_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.fmt_req |=> state_q == S_FMT)
		else $error("arena write did not start a format");

	a_head_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(list_head_q) |->
			$past(state_q == S_FMT || state_q == S_LINK || state_q == S_FREE))
		else $error("list head changed outside format, link or free");

endmodule

`default_nettype wire

// ===== verif/first_fit_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps

module first_fit_free_list_allocator_tb;
	import ffa_pkg::*;

	localparam int WALK_END   = int'(LINK_END);  // end-of-list link as an int
	localparam int HOLD_BEATS = 250;              // results seen before the long stall
	localparam int HOLD_LEN   = 300;              // length of that stall, in cycles
	localparam int PHASES     = 15;
	localparam int PHASE_REQS = 50;

	// one row of the directed table: an arena write, or a request with an
	// optional hand-typed response
	typedef struct {
		bit          is_cfg;
		logic [31:0] cfg_val;
		req_t        req;
		bit          typed;
		rsp_t        rsp;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	req_t               in_data;
	logic               out_valid;
	logic               out_ready;
	rsp_t               out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	first_fit_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the allocator: header store, list head, arena size.
	// hdr_written marks headers whose size field has been stored (format
	// or split); frees only ever target blocks behind such a header, so
	// the block never reads an uninitialized header.
	// ------------------------------------------------------------------
	logic [FIELD_W-1:0] hdr_next    [ARENA_WORDS];
	logic [FIELD_W-1:0] hdr_size    [ARENA_WORDS];
	bit                 hdr_written [ARENA_WORDS];
	logic [FIELD_W-1:0] head_q;
	logic [FIELD_W-1:0] arena_q;

	rsp_t              rsp_expect_q [$];   // responses owed by the block, oldest first
	logic [ADDR_W-1:0] live_q       [$];   // granted payloads not yet freed
	logic [ADDR_W-1:0] spent_q      [$];   // payloads already freed (double-free pool)

	bit no_idle;                           // both sides run back to back
	int errors, n_results, n_req, n_grant, n_nofit, n_reject, n_free, n_fmt, walk_max;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 30)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Expected response for one accepted request; updates the shadow state.
	function automatic rsp_t predict_grant(req_t r);
		rsp_t o;
		int units, want, cur, prev, succ, split, sz, walked;
		units = int'(arena_q);
		want  = int'(r.alloc_size);
		o.status     = ST_DONE;
		o.grant_addr = '0;
		n_req++;
		if (r.req_type == REQ_FREE) begin
			if (r.free_addr == '0 || int'(r.free_addr) >= units) begin
				o.status = ST_REJECT;
			end else begin
				// push at head, no coalescing
				hdr_next[r.free_addr - 1] = head_q;
				head_q = FIELD_W'(r.free_addr - 1);
				n_free++;
			end
		end else if (want == 0) begin
			o.status = ST_REJECT;
		end else begin
			o.status = ST_NOFIT;
			prev     = WALK_END;
			cur      = int'(head_q);
			walked   = 0;
			// first fit; a link past the arena ends the list, and a cycle is
			// cut off after arena_units headers
			while (cur < units && walked < units) begin
				sz = int'(hdr_size[cur]);
				if (sz >= want) begin
					succ  = int'(hdr_next[cur]);
					split = cur + 1 + want;
					// split only if the remainder holds a header plus payload and
					// the new header still lies in the arena
					if (sz > want + 1 && split < units) begin
						hdr_size[split]    = FIELD_W'(sz - want - 1);
						hdr_next[split]    = FIELD_W'(succ);
						hdr_written[split] = 1'b1;
						hdr_size[cur]      = FIELD_W'(want);
						succ               = split;
					end
					if (prev == WALK_END)
						head_q = FIELD_W'(succ);
					else
						hdr_next[prev] = FIELD_W'(succ);
					o.status     = ST_DONE;
					o.grant_addr = ADDR_W'(cur + 1);
					break;
				end
				prev = cur;
				cur  = int'(hdr_next[cur]);
				walked++;
			end
			if (walked > walk_max)
				walk_max = walked;
			if (o.status == ST_DONE)
				n_grant++;
			else
				n_nofit++;
		end
		if (o.status == ST_REJECT)
			n_reject++;
		return o;
	endfunction

	// APB write of arena_units: setup, then access; lands at the access edge.
	// Reformat of the shadow happens at the same edge.
	task automatic write_arena(input logic [31:0] v);
		int u;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ARENA_UNITS, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		u = int'(v[FIELD_W-1:0]);
		if (u < int'(ARENA_MIN))
			u = int'(ARENA_MIN);
		if (u > ARENA_WORDS)
			u = ARENA_WORDS;
		arena_q        = FIELD_W'(u);
		head_q         = '0;
		hdr_next[0]    = LINK_END;
		hdr_size[0]    = FIELD_W'(u - 1);
		hdr_written[0] = 1'b1;
		live_q.delete();
		spent_q.delete();
		n_fmt++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid and let every owed response come back, plus a few cycles
	// so the block is back in idle before a register write.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (rsp_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Offer one request after a random gap; hold it until accepted, then
	// queue its expected response (typed from the table, or predicted).
	task automatic send_request(input req_t r, input bit typed, input rsp_t fixed);
		int   gap;
		rsp_t p;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		p = predict_grant(r);
		rsp_expect_q.push_back(typed ? fixed : p);
		if (r.req_type == REQ_ALLOC && p.status == ST_DONE)
			live_q.push_back(p.grant_addr);
		@(negedge clk);
	endtask

	// Random request, mostly well-formed: allocs of modest size and frees of
	// live blocks; the rest double frees, stale frees and bad addresses.
	function automatic req_t random_request();
		req_t r;
		int   pick, units, cap, idx, a, tries, s;
		r     = '0;
		units = int'(arena_q);
		cap   = (units > 4) ? units / 4 : 1;
		pick  = $urandom_range(0, 99);
		if (pick >= 55 && pick < 88 && live_q.size() != 0) begin
			idx         = $urandom_range(0, live_q.size() - 1);
			r.req_type  = REQ_FREE;
			r.free_addr = live_q[idx];
			spent_q.push_back(live_q[idx]);
			live_q.delete(idx);
		end else if (pick >= 88 && pick < 95) begin
			// double free, or a block left over from an earlier format
			r.req_type = REQ_FREE;
			if (spent_q.size() != 0 && $urandom_range(0, 1)) begin
				r.free_addr = spent_q[$urandom_range(0, spent_q.size() - 1)];
			end else begin
				for (tries = 0; tries < 16; tries++) begin
					a = $urandom_range(1, units - 1);
					if (hdr_written[a - 1]) begin
						r.free_addr = ADDR_W'(a);
						break;
					end
				end
			end
		end else if (pick >= 95) begin
			// zero or outside the arena: rejected
			r.req_type = REQ_FREE;
			if (units < ARENA_WORDS && $urandom_range(0, 2) != 0)
				r.free_addr = ADDR_W'($urandom_range(units, ARENA_WORDS - 1));
			else
				r.free_addr = '0;
		end else begin
			r.req_type = REQ_ALLOC;
			s = $urandom_range(0, 19);
			if (s < 14)
				r.alloc_size = FIELD_W'($urandom_range(1, cap));
			else if (s < 16)
				r.alloc_size = FIELD_W'($urandom_range(1, units));
			else if (s == 16)
				r.alloc_size = '0;
			else if (s == 17)
				r.alloc_size = FIELD_W'(ARENA_WORDS);
			else
				r.alloc_size = FIELD_W'($urandom_range(0, ARENA_WORDS));
		end
		// unused field carries noise; the block must ignore it
		if (r.req_type == REQ_FREE)
			r.alloc_size = FIELD_W'($urandom_range(0, 2047));
		else
			r.free_addr = ADDR_W'($urandom_range(0, ARENA_WORDS - 1));
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input logic [31:0] v);
		dir_row_t d;
		d         = '{default: '0};
		d.is_cfg  = 1'b1;
		d.cfg_val = v;
		return d;
	endfunction

	function automatic dir_row_t row_req(input logic kind, input int val, input bit typed,
			input logic [1:0] st, input int ga);
		dir_row_t d;
		d                = '{default: '0};
		d.req.req_type   = kind;
		if (kind == REQ_ALLOC)
			d.req.alloc_size = FIELD_W'(val);
		else
			d.req.free_addr  = ADDR_W'(val);
		d.typed          = typed;
		d.rsp.status     = st;
		d.rsp.grant_addr = ADDR_W'(ga);
		return d;
	endfunction

	// ------------------------------------------------------------------
	// Result side: checks every response beat against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (rsp_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat status=%0d grant=%0d",
					out_data.status, out_data.grant_addr));
			end else begin
				want = rsp_expect_q.pop_front();
				if (out_data.status !== want.status)
					report_mismatch($sformatf("beat %0d: status %0d, expected %0d",
						n_results, out_data.status, want.status));
				if (out_data.grant_addr !== want.grant_addr)
					report_mismatch($sformatf("beat %0d: grant_addr %0d, expected %0d",
						n_results, out_data.grant_addr, want.grant_addr));
			end
		end
	end

	// Receiver: random back-pressure per beat, plus one long hold-off once
	// enough beats are through, so the block fills and stalls its input.
	initial begin : result_sink
		int  gap;
		bit  held;
		held      = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (!held && n_results >= HOLD_BEATS) begin
				held = 1'b1;
				gap  = HOLD_LEN;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		#20_000_000;
		$display("timeout: %0d responses still owed", rsp_expect_q.size());
		$display("first_fit_free_list_allocator_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus: directed table, then random phases each starting with a
	// fresh arena size.
	// ------------------------------------------------------------------
	initial begin : stimulus
		dir_row_t    dir_rows [$];
		logic [31:0] v;
		int          ph, k;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		no_idle  = 1'b0;
		foreach (hdr_next[i]) begin
			hdr_next[i]    = '0;
			hdr_size[i]    = '0;
			hdr_written[i] = 1'b0;
		end
		// reset state: full arena, one free block at unit 0
		arena_q        = ARENA_RESET;
		head_q         = '0;
		hdr_next[0]    = LINK_END;
		hdr_size[0]    = ARENA_RESET - 1;
		hdr_written[0] = 1'b1;

		// arena of 1024 after reset
		dir_rows.push_back(row_req(REQ_ALLOC, 0,    1, ST_REJECT, 0));  // zero size
		dir_rows.push_back(row_req(REQ_FREE,  0,    1, ST_REJECT, 0));  // zero address
		dir_rows.push_back(row_req(REQ_ALLOC, 1024, 1, ST_NOFIT,  0));  // one more than block
		dir_rows.push_back(row_req(REQ_ALLOC, 1023, 1, ST_DONE,   1));  // whole arena, no split
		dir_rows.push_back(row_req(REQ_ALLOC, 1,    1, ST_NOFIT,  0));  // empty list
		dir_rows.push_back(row_req(REQ_FREE,  1,    1, ST_DONE,   0));
		dir_rows.push_back(row_req(REQ_FREE,  1,    1, ST_DONE,   0));  // double free: self loop
		dir_rows.push_back(row_req(REQ_ALLOC, 1024, 1, ST_NOFIT,  0));  // walk cut off on cycle
		dir_rows.push_back(row_req(REQ_ALLOC, 1021, 0, ST_DONE,   0));  // split near the top
		dir_rows.push_back(row_req(REQ_ALLOC, 1,    0, ST_DONE,   0));  // grants address 1023
		// smallest arena: one block of one unit
		dir_rows.push_back(row_cfg(32'd0));
		dir_rows.push_back(row_req(REQ_FREE,  2,    1, ST_REJECT, 0));  // just past the arena
		dir_rows.push_back(row_req(REQ_FREE,  1023, 1, ST_REJECT, 0));
		dir_rows.push_back(row_req(REQ_ALLOC, 1,    1, ST_DONE,   1));
		dir_rows.push_back(row_req(REQ_ALLOC, 1,    1, ST_NOFIT,  0));
		dir_rows.push_back(row_req(REQ_FREE,  1,    1, ST_DONE,   0));
		// all-ones write clamps to the largest arena; then shrink under a
		// stored split header so the next split would land past the arena
		dir_rows.push_back(row_cfg(32'hFFFF_FFFF));
		dir_rows.push_back(row_req(REQ_ALLOC, 600,  1, ST_DONE,   1));
		dir_rows.push_back(row_cfg(32'd700));
		dir_rows.push_back(row_req(REQ_FREE,  602,  1, ST_DONE,   0));
		dir_rows.push_back(row_req(REQ_ALLOC, 200,  0, ST_DONE,   0));  // whole block, no split
		dir_rows.push_back(row_req(REQ_ALLOC, 699,  0, ST_DONE,   0));
		dir_rows.push_back(row_cfg(32'd1025));                          // clamps to max
		dir_rows.push_back(row_req(REQ_ALLOC, 512,  0, ST_DONE,   0));
		dir_rows.push_back(row_cfg(32'd1));                             // clamps to min
		dir_rows.push_back(row_req(REQ_ALLOC, 2,    1, ST_NOFIT,  0));

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain_results();
				write_arena(dir_rows[i].cfg_val);
			end else begin
				send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
			end
		end

		// random phases: mostly small arenas keep walks short; the full
		// arena, the minimum and a raw 32-bit write each get a phase
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       v = 32'd1024;
				1:       v = 32'd2;
				2:       v = $urandom;
				default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 1024)
				                                          : $urandom_range(4, 64);
			endcase
			drain_results();
			write_arena(v);
			no_idle = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_REQS; k++)
				send_request(random_request(), 1'b0, '0);
		end
		no_idle = 1'b0;

		drain_results();
		repeat (20) @(negedge clk);

		$display("covered %0d requests: %0d grants, %0d no-fit, %0d rejects, %0d frees",
			n_req, n_grant, n_nofit, n_reject, n_free);
		$display("%0d arena formats, longest walk %0d headers, %0d mismatches",
			n_fmt, walk_max, errors);
		if (errors == 0)
			$display("first_fit_free_list_allocator_tb: PASS");
		else
			$display("first_fit_free_list_allocator_tb: FAIL");
		$finish;
	end

endmodule
